// ===== rtl/core/ppca_pkg.sv =====
// ppca_pkg: shared types and constants for the packed pixel channel alu
// no dependencies
`default_nettype none
package ppca_pkg;
  localparam int WORD_BITS = 32;
  localparam int MAX_LANES = 4;
  localparam int LANE_IDX_BITS = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int DIV_STAGES = WORD_BITS;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_INV  = 3'd4,
    CMD_NORM = 3'd5
  } cmd_t;

  localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [0:0] REG_CHANNEL_BITS  = 1'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        div_zero;
  } out_word_t;

  // per-lane context that travels along the pipeline
  typedef struct packed {
    logic             live;
    logic [2:0]       cmd;
    logic [WORD_BITS-1:0] lmask;
    logic [5:0]       off;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/packed_pixel_channel_alu_core.sv =====
// packed_pixel_channel_alu_core: top level of the lane-parallel pixel alu
// depends on ppca_pkg, ppca_lane, ppca_merge
//
// channel | signals                     | handshake
// in      | start, busy, cmd_in         | taken when start && !busy
// out     | done, result                | one-cycle strobe, no stall
// cfg     | cfg_we, cfg_index, cfg_data | taken when cfg_we
//
// one word enters per cycle; each word passes through the input register, the
// bit-per-stage divider pipeline in each lane and the merge register
// busy is always low: every lane is fully pipelined
// rst synchronously clears valid bits and restores 4 lanes of 8 bits
`default_nettype none
module packed_pixel_channel_alu_core import ppca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    cmd_in,
  output logic             done,
  output out_word_t        result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);
  logic [2:0] channel_count;
  logic [5:0] channel_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd4;
      channel_bits  <= 6'd8;
    end else if (cfg_we) begin
      if (cfg_index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[2:0];
      end else begin
        channel_bits <= cfg_data;
      end
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // lane mask: bits ones, bits of 32 or more gives all ones
  logic [WORD_BITS-1:0] lmask;
  assign lmask = (channel_bits >= 6'd32) ? '1
               : ((WORD_BITS'(1) << channel_bits[4:0]) - WORD_BITS'(1));

  logic cmd_ok;
  assign cmd_ok = (cmd_in.cmd <= CMD_NORM);

  logic [WORD_BITS-1:0] lane_r  [MAX_LANES];
  logic                 lane_dz [MAX_LANES];

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    // offset i*bits, at most 3*63 so 8 bits suffice
    logic [7:0]           off;
    lane_ctl_t            ctl;
    logic [WORD_BITS-1:0] x;
    logic [WORD_BITS-1:0] y;
    assign off = 8'(i) * {2'b00, channel_bits};
    assign ctl.live = cmd_ok && (channel_bits != 6'd0) && (3'(i) < channel_count)
                      && (off < 8'(WORD_BITS));
    assign ctl.cmd   = cmd_in.cmd;
    assign ctl.lmask = lmask;
    assign ctl.off   = off[5:0];
    assign x = (cmd_in.operand_a >> off[5:0]) & lmask;
    assign y = (cmd_in.operand_b >> off[5:0]) & lmask;
    ppca_lane u_lane (
      .clk(clk), .rst(rst), .in_valid(accept), .ctl(ctl), .x(x), .y(y),
      .r(lane_r[i]), .dz(lane_dz[i])
    );
  end

  // valid strobe that runs alongside the lane pipelines
  logic valid_pipe [DIV_STAGES+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES + 1; s++) valid_pipe[s] <= 1'b0;
    end else begin
      valid_pipe[0] <= accept;
      for (int s = 1; s < DIV_STAGES + 1; s++) valid_pipe[s] <= valid_pipe[s-1];
    end
  end

  ppca_merge u_merge (
    .clk(clk), .rst(rst), .in_valid(valid_pipe[DIV_STAGES]),
    .lane_r(lane_r), .lane_dz(lane_dz), .done(done), .res(result)
  );
endmodule
`default_nettype wire

// ===== rtl/core/ppca_lane.sv =====
// ppca_lane: one lane; pipelined restoring divider, one quotient bit per stage
// depends on ppca_pkg
`default_nettype none
module ppca_lane import ppca_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire lane_ctl_t            ctl,
  input  wire logic [WORD_BITS-1:0] x,
  input  wire logic [WORD_BITS-1:0] y,
  output logic [WORD_BITS-1:0]      r,
  output logic                      dz
);
  // stage arrays; stage 0 is the input register
  logic [WORD_BITS-1:0] sx   [DIV_STAGES+1];
  logic [WORD_BITS-1:0] sy   [DIV_STAGES+1];
  logic [WORD_BITS-1:0] srem [DIV_STAGES+1];
  logic [WORD_BITS-1:0] sq   [DIV_STAGES+1];
  lane_ctl_t            sc   [DIV_STAGES+1];
  logic [WORD_BITS-1:0] spre [DIV_STAGES+1];
  logic                 sv   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    sx[0]   <= x;
    sy[0]   <= y;
    sc[0]   <= ctl;
    srem[0] <= '0;
    sq[0]   <= '0;
    spre[0] <= '0;
  end

  // non-division result computed in stage 1 so only one multiplier sits there
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    // shifted remainder stays below 2*divisor, so it keeps one extra bit
    logic [WORD_BITS+1:0] trial;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS-1:0] pre;
    assign shifted = {srem[s], sx[s][WORD_BITS-1-s]};
    assign trial = {1'b0, shifted} - {2'b00, sy[s]};
    always_comb begin
      pre = spre[s];
      if (s == 0) begin
        case (sc[s].cmd)
          CMD_ADD:  pre = sx[s] + sy[s];
          CMD_SUB:  pre = sx[s] - sy[s];
          CMD_MUL:  pre = sx[s] * sy[s];
          CMD_INV:  pre = ~sx[s];
          CMD_NORM: pre = sx[s];
          default:  pre = '0;
        endcase
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s+1] <= 1'b0;
      end else begin
        sv[s+1] <= sv[s];
      end
      sx[s+1] <= sx[s];
      sy[s+1] <= sy[s];
      sc[s+1] <= sc[s];
      spre[s+1] <= pre;
      if (!trial[WORD_BITS+1]) begin
        srem[s+1] <= trial[WORD_BITS-1:0];
        sq[s+1]   <= {sq[s][WORD_BITS-2:0], 1'b1};
      end else begin
        srem[s+1] <= shifted[WORD_BITS-1:0];
        sq[s+1]   <= {sq[s][WORD_BITS-2:0], 1'b0};
      end
    end
  end

  logic            last_zero;
  lane_ctl_t       lc;
  logic [WORD_BITS-1:0] raw;
  assign lc = sc[DIV_STAGES];
  assign last_zero = (sy[DIV_STAGES] == '0);
  always_comb begin
    raw = spre[DIV_STAGES];
    dz  = 1'b0;
    if (lc.cmd == CMD_DIV) begin
      raw = last_zero ? lc.lmask : sq[DIV_STAGES];
      dz  = last_zero && lc.live && sv[DIV_STAGES];
    end
    r = lc.live ? ((raw & lc.lmask) << lc.off) : '0;
  end
endmodule
`default_nettype wire

// ===== rtl/core/ppca_merge.sv =====
// ppca_merge: ors lane words together and registers the final result
// depends on ppca_pkg
`default_nettype none
module ppca_merge import ppca_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [WORD_BITS-1:0] lane_r  [MAX_LANES],
  input  wire logic                 lane_dz [MAX_LANES],
  output logic                      done,
  output out_word_t                 res
);
  logic [WORD_BITS-1:0] acc;
  logic                 flag;
  always_comb begin
    acc  = '0;
    flag = 1'b0;
    for (int i = 0; i < MAX_LANES; i++) begin
      acc  = acc | lane_r[i];
      flag = flag | lane_dz[i];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    res.result_word <= acc;
    res.div_zero    <= flag;
  end
endmodule
`default_nettype wire

// ===== rtl/core/ppca_checker.sv =====
// ppca_checker: port-level checks on the pixel alu, bound to the top level
// depends on ppca_pkg
`default_nettype none
module ppca_checker import ppca_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire out_word_t result
);
  localparam int LAT = DIV_STAGES + 2;
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("word lost");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT)) else $error("phantom word");
  a_flag_ones: assert property (@(posedge clk) disable iff (rst)
    (done && result.div_zero) |-> (result.result_word != '0))
    else $error("div by zero lane not all ones");
endmodule

bind packed_pixel_channel_alu_core ppca_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire

// ===== test/packed_pixel_channel_alu_core_test.sv =====
// testbench for packed_pixel_channel_alu_core: directed table then random words
// predicts each lane result in place and checks every done strobe against a queue
// depends on ppca_pkg and the core rtl
`timescale 1ns / 1ps
module packed_pixel_channel_alu_core_test;
  import ppca_pkg::*;

  localparam int LATENCY = WORD_BITS + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t cmd_in = '0;
  logic done;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;

  packed_pixel_channel_alu_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // local copy of the lane layout registers
  logic [2:0] lane_count;
  logic [5:0] lane_width;

  out_word_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycles = 0;

  // lane-by-lane prediction of one packed word
  function automatic out_word_t pixel_math(in_word_t w);
    out_word_t o;
    logic [63:0] lmask, x, y, r, acc;
    int n;
    int off;
    acc = '0;
    o.div_zero = 1'b0;
    n = (lane_count > MAX_LANES) ? MAX_LANES : lane_count;
    if (lane_width != 0 && w.cmd <= CMD_NORM) begin
      lmask = ~64'd0 >> (64 - lane_width);
      for (int i = 0; i < n; i++) begin
        off = i * lane_width;
        if (off >= WORD_BITS) break;
        x = ({32'd0, w.operand_a} >> off) & lmask;
        y = ({32'd0, w.operand_b} >> off) & lmask;
        case (w.cmd)
          CMD_ADD: r = x + y;
          CMD_SUB: r = x - y;
          CMD_MUL: r = x * y;
          CMD_DIV: begin
            if (y == 0) begin
              r = lmask;
              o.div_zero = 1'b1;
            end else begin
              r = x / y;
            end
          end
          CMD_INV: r = ~x;
          default: r = x;
        endcase
        acc |= (r & lmask) << off;
      end
    end
    o.result_word = acc[31:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // scoreboard: every done strobe is one result word, checked in order
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", result.result_word, 32'd0);
      end else begin
        out_word_t exp_w;
        exp_w = pending_results.pop_front();
        if (result.result_word !== exp_w.result_word)
          report_mismatch("result_word", result.result_word, exp_w.result_word);
        if (result.div_zero !== exp_w.div_zero)
          report_mismatch("div_zero", {31'd0, result.div_zero}, {31'd0, exp_w.div_zero});
        words_checked <= words_checked + 1;
      end
    end
  end

  // watchdog for a stuck pipeline
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // settle the pipeline before touching the layout registers
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_layout(input logic idx, input logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHANNEL_COUNT) lane_count = val[2:0];
    else lane_width = val;
    @(posedge clk);
  endtask

  // present one word, hold start until it is taken, optionally keep start raised
  task automatic send_word(input in_word_t w, input bit keep_start);
    cmd_in <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(pixel_math(w));
    words_sent++;
    if (!keep_start) start <= 1'b0;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // directed rows; chk marks rows whose answer is typed in
  typedef struct {
    logic [2:0] cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit chk;
    logic [31:0] want;
    logic want_dz;
  } row_t;

  row_t rows[$];

  task automatic run_rows();
    foreach (rows[k]) begin
      in_word_t w;
      out_word_t p;
      w.cmd = rows[k].cmd;
      w.operand_a = rows[k].a;
      w.operand_b = rows[k].b;
      if (rows[k].chk) begin
        p = pixel_math(w);
        if (p.result_word !== rows[k].want || p.div_zero !== rows[k].want_dz)
          report_mismatch("table row", p.result_word, rows[k].want);
      end
      // rows go back to back; start drops after the last one
      send_word(w, k != rows.size() - 1);
    end
    rows.delete();
  endtask

  // one random phase under a given lane layout
  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      in_word_t w;
      int gap;
      int sel;
      w.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      sel = $urandom_range(0, 9);
      w.operand_a = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'd0 : $urandom;
      sel = $urandom_range(0, 9);
      // sparse divisors make zero lanes common
      w.operand_b = (sel < 2) ? 32'd0 : (sel < 4) ? ($urandom & $urandom & $urandom)
                  : (sel == 4) ? 32'hFFFF_FFFF : $urandom;
      gap = pick_gap();
      send_word(w, gap == 0);
      if (gap != 0) repeat (gap) @(posedge clk);
    end
  endtask

  typedef struct { logic [2:0] cnt; logic [5:0] bits; } layout_t;

  initial begin
    layout_t layouts[$];
    lane_count = 3'd4;
    lane_width = 6'd8;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset layout: four 8-bit lanes
    rows.push_back('{CMD_ADD, 32'h01FF_7F80, 32'h0101_0180, 1, 32'h0200_80_00, 0});
    rows.push_back('{CMD_SUB, 32'h0000_0000, 32'h0102_0304, 1, 32'hFFFE_FDFC, 0});
    rows.push_back('{CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0101_0101, 0});
    rows.push_back('{CMD_DIV, 32'h6464_6464, 32'h0005_0A00, 1, 32'hFF14_0AFF, 1});
    rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'h0101_0101, 1, 32'hFFFF_FFFF, 0});
    rows.push_back('{CMD_INV, 32'h0F0F_00FF, 32'h1234_5678, 1, 32'hF0F0_FF00, 0});
    rows.push_back('{CMD_NORM, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1, 32'hDEAD_BEEF, 0});
    rows.push_back('{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0});
    rows.push_back('{3'd7, 32'h1234_5678, 32'd0, 1, 32'd0, 0});
    rows.push_back('{CMD_MUL, 32'h1234_5678, 32'h9ABC_DEF0, 0, 32'd0, 0});
    run_rows();
    drain();

    // one 32-bit lane, extremes
    write_layout(REG_CHANNEL_COUNT, 6'd1);
    write_layout(REG_CHANNEL_BITS, 6'd32);
    rows.push_back('{CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'd0, 0});
    rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, 1});
    rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd1, 0});
    rows.push_back('{CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd1, 0});
    run_rows();
    drain();

    // zero lanes, then zero width
    write_layout(REG_CHANNEL_COUNT, 6'd0);
    rows.push_back('{CMD_DIV, 32'h1234_5678, 32'd0, 1, 32'd0, 0});
    run_rows();
    drain();
    write_layout(REG_CHANNEL_COUNT, 6'd4);
    write_layout(REG_CHANNEL_BITS, 6'd0);
    rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'd0, 1, 32'd0, 0});
    run_rows();
    drain();

    // too many lanes clamps to four; wide lanes run off the word
    write_layout(REG_CHANNEL_COUNT, 6'd7);
    write_layout(REG_CHANNEL_BITS, 6'd20);
    rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'hFFFF_FFFF, 1});
    rows.push_back('{CMD_INV, 32'd0, 32'd0, 1, 32'hFFFF_FFFF, 0});
    run_rows();
    drain();
    write_layout(REG_CHANNEL_BITS, 6'd63);
    rows.push_back('{CMD_INV, 32'h0000_FFFF, 32'd0, 1, 32'hFFFF_0000, 0});
    rows.push_back('{CMD_SUB, 32'd0, 32'd1, 1, 32'hFFFF_FFFF, 0});
    run_rows();
    drain();

    // random phases over a spread of layouts, extremes included
    layouts.push_back('{3'd4, 6'd8});
    layouts.push_back('{3'd1, 6'd1});
    layouts.push_back('{3'd4, 6'd1});
    layouts.push_back('{3'd2, 6'd16});
    layouts.push_back('{3'd3, 6'd11});
    layouts.push_back('{3'd1, 6'd32});
    layouts.push_back('{3'd7, 6'd9});
    layouts.push_back('{3'd5, 6'd40});
    layouts.push_back('{3'd0, 6'd8});
    layouts.push_back('{3'd4, 6'd0});
    for (int k = 0; k < 6; k++)
      layouts.push_back('{3'($urandom_range(0, 7)), 6'($urandom)});
    foreach (layouts[k]) begin
      write_layout(REG_CHANNEL_COUNT, {3'd0, layouts[k].cnt});
      write_layout(REG_CHANNEL_BITS, layouts[k].bits);
      // most words go to the useful layouts
      random_phase((layouts[k].cnt == 0 || layouts[k].bits == 0) ? 15 : 60);
      start <= 1'b0;
      drain();
    end

    $display("covered %0d words over %0d lane layouts, %0d results checked",
             words_sent, layouts.size(), words_checked);
    $display("all six operations, unknown codes, zero divisors and off-word lanes");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
